// ===== rtl/rgt_pkg.sv =====
`timescale 1ns / 1ps

package rgt_pkg;

    // grid defaults
    localparam int GRID_COLS_DEF = 16;
    localparam int GRID_ROWS_DEF = 16;

    // field widths
    localparam int COORD_W      = 24;
    localparam int DIR_W        = 16;
    localparam int MAG_W        = 16;
    localparam int CELL_W       = 23;
    localparam int TIME_W       = 32;
    localparam int CELL_INDEX_W = 8;
    localparam int IDX_CALC_W   = 11;

    // time = dist * 2^22 / |dir|
    localparam int FRAC_SHIFT = 22;
    localparam int LOW_W      = TIME_W - FRAC_SHIFT;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    // divider retires this many quotient bits per cycle
    localparam int RADIX_BITS = 2;
    localparam int DIV_STEPS  = TIME_W / RADIX_BITS;

    localparam int MAX_RESULTS = 31;
    localparam int CNT_W       = 5;

    localparam logic [CELL_W-1:0] CELL_SIZE_RESET = CELL_W'(16384);

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = CELL_W;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CELL_WIDTH  = 1'b0,
        CFG_CELL_HEIGHT = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
        logic signed [DIR_W-1:0]   dir_x;
        logic signed [DIR_W-1:0]   dir_y;
    } in_word_t;

    typedef struct packed {
        logic [CELL_INDEX_W-1:0] cell_index;
        logic                    last;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIND,
        ST_DIV,
        ST_TIMES,
        ST_EMIT
    } rgt_state_t;

    typedef struct packed {
        logic accept;
        logic find;
        logic div_load;
        logic div_run;
        logic load_times;
        logic step;
        logic cap;
    } rgt_cmd_t;

    typedef struct packed {
        logic find_done;
        logic origin_out;
        logic out_free;
        logic word_last;
    } rgt_status_t;

endpackage

// ===== rtl/rgt_div.sv =====
`timescale 1ns / 1ps

module rgt_div
    import rgt_pkg::*;
(
    input  logic              clk,
    input  logic              load,
    input  logic              run,
    input  logic [CELL_W-1:0] numer,
    input  logic [MAG_W-1:0]  denom,
    output logic [TIME_W-1:0] quo
);

    logic [MAG_W-1:0]  rem_reg;
    logic [MAG_W-1:0]  rem_next;
    logic [TIME_W-1:0] q_reg;
    logic [TIME_W-1:0] q_next;
    logic [MAG_W-1:0]  d_reg;
    logic              sat_reg;
    logic              sat_next;

    // quotient overflows 32 bits when the high part of the dividend reaches the divisor
    assign sat_next = (denom == '0) ||
                      ({{(MAG_W-(CELL_W-LOW_W)){1'b0}}, numer[CELL_W-1:LOW_W]} >= denom);

    always_comb
    begin : div_step_comb
        logic [MAG_W-1:0]  r;
        logic [TIME_W-1:0] q;
        logic [MAG_W:0]    t;
        r = rem_reg;
        q = q_reg;
        t = '0;
        for (int k = 0; k < RADIX_BITS; k++)
        begin
            t = {r, q[TIME_W-1]};
            if (t >= {1'b0, d_reg})
            begin
                q = {q[TIME_W-2:0], 1'b1};
                r = MAG_W'(t - {1'b0, d_reg});
            end
            else
            begin
                q = {q[TIME_W-2:0], 1'b0};
                r = t[MAG_W-1:0];
            end
        end
        rem_next = r;
        q_next   = q;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rem_reg <= MAG_W'(numer[CELL_W-1:LOW_W]);
            q_reg   <= {numer[LOW_W-1:0], {FRAC_SHIFT{1'b0}}};
            d_reg   <= denom;
            sat_reg <= sat_next;
        end
        else if (run)
        begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    assign quo = sat_reg ? TIME_MAX : q_reg;

endmodule

// ===== rtl/rgt_datapath.sv =====
`timescale 1ns / 1ps

module rgt_datapath
    import rgt_pkg::*;
#(
    parameter int GRID_COLS = GRID_COLS_DEF,
    parameter int GRID_ROWS = GRID_ROWS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  in_word_t               in_data,
    input  logic                   out_stall,
    output logic                   out_valid,
    output out_word_t              out_data,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  rgt_cmd_t               cmd,
    output rgt_status_t            status
);

    localparam int COL_BITS = $clog2(GRID_COLS) + 1;
    localparam int ROW_BITS = $clog2(GRID_ROWS) + 1;

    logic [CELL_W-1:0]   cw_reg;
    logic [CELL_W-1:0]   ch_reg;
    logic [CELL_W-1:0]   cw_eff;
    logic [CELL_W-1:0]   ch_eff;

    logic [CELL_W-1:0]   rem_x_reg;
    logic [CELL_W-1:0]   rem_y_reg;
    logic                neg_x_reg;
    logic                neg_y_reg;
    logic [COL_BITS-1:0] col_reg;
    logic [ROW_BITS-1:0] row_reg;
    logic                sign_x_reg;
    logic                sign_y_reg;
    logic [MAG_W-1:0]    mag_x_reg;
    logic [MAG_W-1:0]    mag_y_reg;
    logic [TIME_W-1:0]   next_time_x_reg;
    logic [TIME_W-1:0]   next_time_y_reg;
    logic [TIME_W-1:0]   time_step_x_reg;
    logic [TIME_W-1:0]   time_step_y_reg;

    logic                out_valid_reg;
    out_word_t           out_data_reg;

    logic                fin_x;
    logic                fin_y;
    logic [CELL_W-1:0]   numer_nx;
    logic [CELL_W-1:0]   numer_ny;
    logic [TIME_W-1:0]   quo_nx;
    logic [TIME_W-1:0]   quo_ny;
    logic [TIME_W-1:0]   quo_sx;
    logic [TIME_W-1:0]   quo_sy;

    logic                step_x;
    logic [COL_BITS-1:0] col_step;
    logic [ROW_BITS-1:0] row_step;
    logic [COL_BITS-1:0] col_new;
    logic [ROW_BITS-1:0] row_new;
    logic                new_in_grid;
    logic [IDX_CALC_W-1:0] idx_full;
    logic [TIME_W:0]     sum_x;
    logic [TIME_W:0]     sum_y;
    logic [TIME_W-1:0]   add_x;
    logic [TIME_W-1:0]   add_y;

    // a zero cell size behaves as one
    assign cw_eff = (cw_reg == '0) ? CELL_W'(1) : cw_reg;
    assign ch_eff = (ch_reg == '0) ? CELL_W'(1) : ch_reg;

    // start cell by repeated subtraction, stops once past the grid edge
    assign fin_x = neg_x_reg || (rem_x_reg < cw_eff) || (col_reg == COL_BITS'(GRID_COLS));
    assign fin_y = neg_y_reg || (rem_y_reg < ch_eff) || (row_reg == ROW_BITS'(GRID_ROWS));

    assign status.find_done  = fin_x && fin_y;
    assign status.origin_out = neg_x_reg || neg_y_reg ||
                               (col_reg == COL_BITS'(GRID_COLS)) ||
                               (row_reg == ROW_BITS'(GRID_ROWS));

    // distance to the first boundary in the direction of travel
    assign numer_nx = sign_x_reg ? rem_x_reg : CELL_W'(cw_eff - rem_x_reg);
    assign numer_ny = sign_y_reg ? rem_y_reg : CELL_W'(ch_eff - rem_y_reg);

    rgt_div u_div_nx (
        .clk   (clk),
        .load  (cmd.div_load),
        .run   (cmd.div_run),
        .numer (numer_nx),
        .denom (mag_x_reg),
        .quo   (quo_nx)
    );

    rgt_div u_div_ny (
        .clk   (clk),
        .load  (cmd.div_load),
        .run   (cmd.div_run),
        .numer (numer_ny),
        .denom (mag_y_reg),
        .quo   (quo_ny)
    );

    rgt_div u_div_sx (
        .clk   (clk),
        .load  (cmd.div_load),
        .run   (cmd.div_run),
        .numer (cw_eff),
        .denom (mag_x_reg),
        .quo   (quo_sx)
    );

    rgt_div u_div_sy (
        .clk   (clk),
        .load  (cmd.div_load),
        .run   (cmd.div_run),
        .numer (ch_eff),
        .denom (mag_y_reg),
        .quo   (quo_sy)
    );

    // one cell step; x only on strictly earlier boundary
    assign step_x   = next_time_x_reg < next_time_y_reg;
    assign col_step = sign_x_reg ? COL_BITS'(col_reg - COL_BITS'(1))
                                 : COL_BITS'(col_reg + COL_BITS'(1));
    assign row_step = sign_y_reg ? ROW_BITS'(row_reg - ROW_BITS'(1))
                                 : ROW_BITS'(row_reg + ROW_BITS'(1));
    assign col_new  = step_x ? col_step : col_reg;
    assign row_new  = step_x ? row_reg : row_step;

    // leaving below zero wraps to all ones, which also fails the bound
    assign new_in_grid = (col_new < COL_BITS'(GRID_COLS)) && (row_new < ROW_BITS'(GRID_ROWS));

    assign status.word_last = !new_in_grid || cmd.cap;
    assign status.out_free  = !out_valid_reg || !out_stall;

    assign idx_full = IDX_CALC_W'(col_reg) +
                      IDX_CALC_W'(IDX_CALC_W'(GRID_COLS) * IDX_CALC_W'(row_reg));

    assign sum_x = {1'b0, next_time_x_reg} + {1'b0, time_step_x_reg};
    assign sum_y = {1'b0, next_time_y_reg} + {1'b0, time_step_y_reg};
    assign add_x = sum_x[TIME_W] ? TIME_MAX : sum_x[TIME_W-1:0];
    assign add_y = sum_y[TIME_W] ? TIME_MAX : sum_y[TIME_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cw_reg        <= CELL_SIZE_RESET;
            ch_reg        <= CELL_SIZE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CELL_WIDTH:  cw_reg <= cfg_data;
                    CFG_CELL_HEIGHT: ch_reg <= cfg_data;
                    default:         ;
                endcase
            end
            if (cmd.step)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            rem_x_reg  <= in_data.origin_x[CELL_W-1:0];
            rem_y_reg  <= in_data.origin_y[CELL_W-1:0];
            neg_x_reg  <= in_data.origin_x[COORD_W-1];
            neg_y_reg  <= in_data.origin_y[COORD_W-1];
            col_reg    <= '0;
            row_reg    <= '0;
            sign_x_reg <= in_data.dir_x[DIR_W-1];
            sign_y_reg <= in_data.dir_y[DIR_W-1];
            mag_x_reg  <= in_data.dir_x[DIR_W-1] ? MAG_W'(-in_data.dir_x) : MAG_W'(in_data.dir_x);
            mag_y_reg  <= in_data.dir_y[DIR_W-1] ? MAG_W'(-in_data.dir_y) : MAG_W'(in_data.dir_y);
        end
        else if (cmd.find)
        begin
            if (!fin_x)
            begin
                rem_x_reg <= CELL_W'(rem_x_reg - cw_eff);
                col_reg   <= COL_BITS'(col_reg + COL_BITS'(1));
            end
            if (!fin_y)
            begin
                rem_y_reg <= CELL_W'(rem_y_reg - ch_eff);
                row_reg   <= ROW_BITS'(row_reg + ROW_BITS'(1));
            end
        end
        else if (cmd.load_times)
        begin
            next_time_x_reg <= quo_nx;
            next_time_y_reg <= quo_ny;
            time_step_x_reg <= quo_sx;
            time_step_y_reg <= quo_sy;
        end
        else if (cmd.step)
        begin
            col_reg <= col_new;
            row_reg <= row_new;
            if (step_x)
                next_time_x_reg <= add_x;
            else
                next_time_y_reg <= add_y;
            out_data_reg.cell_index <= idx_full[CELL_INDEX_W-1:0];
            out_data_reg.last       <= status.word_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== rtl/rgt_ctrl.sv =====
`timescale 1ns / 1ps

module rgt_ctrl
    import rgt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  rgt_status_t status,
    output rgt_cmd_t    cmd
);

    rgt_state_t       state_reg;
    rgt_state_t       state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_FIND;
            end
            ST_FIND:
            begin
                if (status.find_done)
                    state_next = status.origin_out ? ST_IDLE : ST_DIV;
            end
            ST_DIV:
            begin
                if (count_reg == CNT_W'(DIV_STEPS - 1))
                    state_next = ST_TIMES;
            end
            ST_TIMES:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free && status.word_last)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        in_stall   = 1'b1;
        count_next = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall   = 1'b0;
                cmd.accept = in_valid;
            end
            ST_FIND:
            begin
                cmd.find     = 1'b1;
                cmd.div_load = status.find_done && !status.origin_out;
            end
            ST_DIV:
            begin
                cmd.div_run = 1'b1;
                count_next  = CNT_W'(count_reg + CNT_W'(1));
            end
            ST_TIMES:
            begin
                cmd.load_times = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.step   = status.out_free;
                cmd.cap    = count_reg == CNT_W'(MAX_RESULTS - 1);
                count_next = status.out_free ? CNT_W'(count_reg + CNT_W'(1)) : count_reg;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/ray_grid_traversal_top.sv =====
`timescale 1ns / 1ps

// Walks one ray at a time through a GRID_COLS x GRID_ROWS grid and sends the index of every
// cell it crosses, col + GRID_COLS * row, with last set on the final cell (at most 31 cells a
// ray). A ray is accepted, then its start cell is found by repeated subtraction of the cell
// size, both axes side by side; then the four boundary and step time divisions run (2
// quotient bits a cycle), the times are loaded, and one cell a cycle goes out while the
// output is taken. A ray whose origin lies outside the grid yields no word. The next ray is
// taken once the last word is in the output register. The user must write the cell size
// registers only while no ray is in flight; the block itself does not enforce this.
module ray_grid_traversal_top
    import rgt_pkg::*;
#(
    parameter int GRID_COLS = GRID_COLS_DEF,
    parameter int GRID_ROWS = GRID_ROWS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  in_word_t               in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output out_word_t              out_data,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    rgt_cmd_t    cmd;
    rgt_status_t status;

    rgt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    rgt_datapath #(
        .GRID_COLS (GRID_COLS),
        .GRID_ROWS (GRID_ROWS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// ===== tb/sv/tb_ray_grid_traversal_top.sv =====
`timescale 1ns / 1ps

module tb_ray_grid_traversal_top;
    import rgt_pkg::*;

    localparam int COLS           = GRID_COLS_DEF;
    localparam int ROWS           = GRID_ROWS_DEF;
    localparam int RAYS_PER_PHASE = 56;
    localparam int N_PHASES       = 5;
    localparam int DRAIN_CYCLES   = 80;
    localparam int CYCLE_LIMIT    = 600000;
    localparam int MAX_REPORTS    = 100;

    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          in_valid  = 1'b0;
    logic          in_stall;
    in_word_t      in_data   = '0;
    logic          out_valid;
    logic          out_stall = 1'b0;
    out_word_t     out_data;
    logic          cfg_we    = 1'b0;
    cfg_index_t    cfg_index = CFG_CELL_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // local copy of the cell size registers
    logic [CELL_W-1:0] cell_w_q = CELL_SIZE_RESET;
    logic [CELL_W-1:0] cell_h_q = CELL_SIZE_RESET;

    out_word_t pending_cells[$];

    int err_cnt       = 0;
    int words_checked = 0;
    int rays_sent     = 0;
    int rays_outside  = 0;
    int settings_used = 1;
    int cycles        = 0;
    int burst_left    = 0;
    int stall_mode    = 0;
    int stall_left    = 0;

    typedef struct {
        int ox;
        int oy;
        int dx;
        int dy;
        int known_words;   // -1: predicted, 0: none, 1: one word with last set
        int known_index;
    } probe_t;

    localparam int N_PROBES = 22;

    // default cells are 64.0 units, the grid spans 0 .. 262143 on each axis
    probe_t probes [N_PROBES] = '{
        '{0,        0,        0,      -16384, 1, 0},    // on a boundary heading out
        '{0,        0,        -16384, 0,      1, 0},
        '{-1,       0,        100,    100,    0, 0},
        '{0,        -1,       100,    100,    0, 0},
        '{262144,   5000,     1,      1,      0, 0},
        '{5000,     262144,   1,      1,      0, 0},
        '{-8388608, -8388608, -32768, -32768, 0, 0},
        '{8388607,  8388607,  32767,  32767,  0, 0},
        '{262143,   262143,   16384,  0,      1, 255},
        '{262143,   0,        32767,  32767,  -1, 0},
        '{100,      100,      0,      0,      -1, 0},   // no direction at all
        '{1,        1,        16384,  16384,  -1, 0},   // full diagonal, ties step in y
        '{262143,   262143,   -32768, -32768, -1, 0},
        '{49152,    81920,    -8000,  -9000,  -1, 0},
        '{32768,    32768,    32767,  -32768, -1, 0},
        '{32768,    32768,    -32768, 32767,  -1, 0},
        '{131072,   131072,   1,      -1,     -1, 0},
        '{0,        262143,   16384,  -1,     -1, 0},
        '{200000,   10,       -1,     30000,  -1, 0},
        '{65536,    65536,    12345,  0,      -1, 0},
        '{65536,    65536,    0,      -23456, -1, 0},
        '{70000,    150000,   5000,   4000,   -1, 0}
    };

    ray_grid_traversal_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic longint floor_div(longint a, longint b);
        if (a >= 0)
            return a / b;
        return -((-a + b - 1) / b);
    endfunction

    // |gap| * 2^22 / |speed| as unsigned Q16.16, saturated
    function automatic logic [TIME_W-1:0] crossing_time(longint gap, longint speed);
        longint unsigned num;
        longint unsigned den;
        longint unsigned q;
        if (speed == 0)
            return TIME_MAX;
        num = (gap < 0) ? -gap : gap;
        den = (speed < 0) ? -speed : speed;
        q = (num << FRAC_SHIFT) / den;
        return (q > 64'hFFFF_FFFF) ? TIME_MAX : q[TIME_W-1:0];
    endfunction

    function automatic logic [TIME_W-1:0] add_sat(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
    endfunction

    // walks the ray through the grid and queues every word it should produce
    function automatic void trace_cells(in_word_t r);
        longint ox;
        longint oy;
        longint dx;
        longint dy;
        longint cw;
        longint ch;
        longint col;
        longint row;
        logic   neg_x;
        logic   neg_y;
        logic   in_bounds;
        logic [TIME_W-1:0] t_x;
        logic [TIME_W-1:0] t_y;
        logic [TIME_W-1:0] s_x;
        logic [TIME_W-1:0] s_y;
        out_word_t w;
        ox = longint'($signed(r.origin_x));
        oy = longint'($signed(r.origin_y));
        dx = longint'($signed(r.dir_x));
        dy = longint'($signed(r.dir_y));
        cw = (cell_w_q == 0) ? 1 : longint'(cell_w_q);
        ch = (cell_h_q == 0) ? 1 : longint'(cell_h_q);
        col = floor_div(ox, cw);
        row = floor_div(oy, ch);
        if (col < 0 || col >= COLS || row < 0 || row >= ROWS)
            return;
        neg_x = (dx < 0);
        neg_y = (dy < 0);
        t_x = crossing_time((col + (neg_x ? 0 : 1)) * cw - ox, dx);
        t_y = crossing_time((row + (neg_y ? 0 : 1)) * ch - oy, dy);
        s_x = crossing_time(cw, dx);
        s_y = crossing_time(ch, dy);
        for (int n = 0; n < MAX_RESULTS; n++)
        begin
            w.cell_index = CELL_INDEX_W'(col + COLS * row);
            if (t_x < t_y)
            begin
                t_x = add_sat(t_x, s_x);
                col += neg_x ? -1 : 1;
            end
            else
            begin
                t_y = add_sat(t_y, s_y);
                row += neg_y ? -1 : 1;
            end
            in_bounds = (col >= 0 && col < COLS && row >= 0 && row < ROWS);
            w.last = !in_bounds || (n == MAX_RESULTS - 1);
            pending_cells.push_back(w);
            if (!in_bounds)
                break;
        end
    endfunction

    function automatic logic signed [DIR_W-1:0] random_dir();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return DIR_W'(int'($urandom_range(0, 16)) - 8);
            2: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            default: return DIR_W'($urandom);
        endcase
    endfunction

    // mostly rays that start inside the grid, some snapped to a boundary, some pure noise
    function automatic in_word_t random_ray();
        in_word_t r;
        longint cw;
        longint ch;
        longint span_x;
        longint span_y;
        longint ox;
        longint oy;
        if ($urandom_range(0, 9) == 0)
        begin
            r.origin_x = COORD_W'($urandom);
            r.origin_y = COORD_W'($urandom);
            r.dir_x    = DIR_W'($urandom);
            r.dir_y    = DIR_W'($urandom);
            return r;
        end
        cw = (cell_w_q == 0) ? 1 : longint'(cell_w_q);
        ch = (cell_h_q == 0) ? 1 : longint'(cell_h_q);
        span_x = (COLS * cw > 64'd8388608) ? 64'd8388608 : COLS * cw;
        span_y = (ROWS * ch > 64'd8388608) ? 64'd8388608 : ROWS * ch;
        ox = $urandom_range(0, 32'(span_x - 1));
        oy = $urandom_range(0, 32'(span_y - 1));
        if ($urandom_range(0, 3) == 0)
            ox = (ox / cw) * cw;
        if ($urandom_range(0, 3) == 0)
            oy = (oy / ch) * ch;
        r.origin_x = COORD_W'(ox);
        r.origin_y = COORD_W'(oy);
        r.dir_x    = random_dir();
        r.dir_y    = random_dir();
        return r;
    endfunction

    // holds the word until taken, then either carries on with the burst or idles a while
    task automatic send_ray(in_word_t r, int known_words, int known_index);
        int before_cnt;
        out_word_t w;
        in_data  <= r;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        before_cnt = pending_cells.size();
        if (known_words < 0)
            trace_cells(r);
        else if (known_words == 1)
        begin
            w.cell_index = CELL_INDEX_W'(known_index);
            w.last       = 1'b1;
            pending_cells.push_back(w);
        end
        if (pending_cells.size() == before_cnt)
            rays_outside++;
        rays_sent++;
        @(negedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            in_valid <= 1'b0;
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 5);
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_cells.size() != 0)
            @(negedge clk);
        // a ray that starts outside the grid may still be in flight
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_cell_size(cfg_index_t which, logic [CELL_W-1:0] size);
        cfg_index <= which;
        cfg_data  <= size;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (which == CFG_CELL_WIDTH)
            cell_w_q = size;
        else
            cell_h_q = size;
        @(negedge clk);
    endtask

    // receiver stalls in modes that change every so often
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 150);
        end
        else
            stall_left--;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 9) < 6);
            default: out_stall <= (stall_left % 3 == 0);
        endcase
    end

    always @(posedge clk)
    begin : check_words
        out_word_t exp_w;
        if (rst_n && out_valid && !out_stall)
        begin
            words_checked++;
            if (pending_cells.size() == 0)
            begin
                err_cnt++;
                if (err_cnt <= MAX_REPORTS)
                    $display("%0t: unexpected word, expected none, got index %0d last %0b",
                             $time, out_data.cell_index, out_data.last);
            end
            else
            begin
                exp_w = pending_cells.pop_front();
                if (out_data.cell_index !== exp_w.cell_index)
                begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                        $display("%0t: cell_index mismatch, expected %0d, got %0d",
                                 $time, exp_w.cell_index, out_data.cell_index);
                end
                if (out_data.last !== exp_w.last)
                begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                        $display("%0t: last mismatch, expected %0b, got %0b",
                                 $time, exp_w.last, out_data.last);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("%0t: timed out with %0d words outstanding", $time, pending_cells.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        logic [CELL_W-1:0] phase_w [N_PHASES];
        logic [CELL_W-1:0] phase_h [N_PHASES];
        in_word_t r;

        // smallest cells, a zero width register, largest cells, then random sizes
        phase_w[0] = 23'd1;
        phase_h[0] = 23'd1;
        phase_w[1] = 23'd0;
        phase_h[1] = 23'd2;
        phase_w[2] = 23'h7F_FFFF;
        phase_h[2] = 23'h7F_FFFF;
        phase_w[3] = CELL_W'($urandom_range(1, 40000));
        phase_h[3] = CELL_W'($urandom_range(1, 40000));
        phase_w[4] = CELL_W'($urandom_range(1, 8388607));
        phase_h[4] = CELL_W'($urandom_range(1, 600000));

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < N_PROBES; i++)
        begin
            r.origin_x = COORD_W'(probes[i].ox);
            r.origin_y = COORD_W'(probes[i].oy);
            r.dir_x    = DIR_W'(probes[i].dx);
            r.dir_y    = DIR_W'(probes[i].dy);
            send_ray(r, probes[i].known_words, probes[i].known_index);
        end

        for (int p = 0; p < N_PHASES; p++)
        begin
            wait_idle();
            write_cell_size(CFG_CELL_WIDTH, phase_w[p]);
            write_cell_size(CFG_CELL_HEIGHT, phase_h[p]);
            settings_used++;
            for (int k = 0; k < RAYS_PER_PHASE; k++)
                send_ray(random_ray(), -1, 0);
        end
        wait_idle();

        $display("%0d rays sent over %0d cell size settings, %0d of them starting off the grid",
                 rays_sent, settings_used, rays_outside);
        $display("%0d cell words checked, %0d mismatches", words_checked, err_cnt);
        if (err_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
